[sv/cau_pkg.sv]
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  // Width of a dividend magnitude after the fractional shift.
  localparam int NW = 64 + FRAC_BITS;
  // Quotient bits kept; anything at or beyond 2^33 is saturated anyway.
  localparam int QW = 34;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_ADDR  = 4'd4,
    OP_SUBR  = 4'd5,
    OP_SCALE = 4'd6,
    OP_DIVR  = 4'd7,
    OP_CONJ  = 4'd8,
    OP_NEG   = 4'd9
  } op_t;

  // Control travelling with each item.
  typedef struct packed {
    logic [3:0] op;
    logic       neg_re;
    logic       neg_im;
    logic       dz;
  } ctl_t;

endpackage

[sv/cau_div.sv]
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
module cau_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [cau_pkg::NW-1:0] num,
  input  logic [63:0]            den,
  output logic [cau_pkg::QW-1:0] quo
);
  import cau_pkg::*;

  // Bits of the numerator that can yield quotient bits beyond QW saturate.
  localparam int STG = NW;

  logic [NW-1:0]  n_q   [STG+1];
  logic [64:0]    r_q   [STG+1];
  logic [63:0]    d_q   [STG+1];
  logic [QW-1:0]  q_q   [STG+1];
  logic           big_q [STG+1];

  assign n_q[0]   = num;
  assign r_q[0]   = '0;
  assign d_q[0]   = den;
  assign q_q[0]   = '0;
  assign big_q[0] = 1'b0;

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [65:0] sh;
    logic [65:0] df;
    logic        take;
    assign sh   = {r_q[s], n_q[s][NW-1-s]};
    assign df   = sh - {2'b00, d_q[s]};
    assign take = !df[65];
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[s+1] <= n_q[s];
        d_q[s+1] <= d_q[s];
        r_q[s+1] <= take ? df[64:0] : sh[64:0];
        q_q[s+1] <= {q_q[s][QW-2:0], take};
        big_q[s+1] <= big_q[s] | q_q[s][QW-1];
      end
    end
  end

  // Any overflowed high bit forces a value at or above 2^33.
  assign quo = big_q[STG] ? {2'b10, {(QW-2){1'b0}}} : q_q[STG];
endmodule

[sv/complex_arithmetic_unit.sv]
// Top level of the pipelined complex arithmetic unit.
//
//  channel | signals                                   | dir
//  in      | in_valid/in_ready, opcode a_re a_im b_re b_im | sink
//  out     | out_valid/out_ready, res_re res_im overflow div_by_zero | source
//
// One transfer per cycle in each direction unless the output stalls. Stages in order:
// product, sum, sign/magnitude, 80 divider stages (one quotient bit each),
// then saturation into the output register. Every operation takes the same path.
// rst clears all valid bits. A stall at the output freezes the whole
// pipeline; in_ready follows out_ready or an empty output register.
module complex_arithmetic_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    opcode,
  input  logic signed [cau_pkg::DW-1:0] a_re,
  input  logic signed [cau_pkg::DW-1:0] a_im,
  input  logic signed [cau_pkg::DW-1:0] b_re,
  input  logic signed [cau_pkg::DW-1:0] b_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cau_pkg::DW-1:0] res_re,
  output logic signed [cau_pkg::DW-1:0] res_im,
  output logic                          overflow,
  output logic                          div_by_zero
);
  import cau_pkg::*;

  localparam int DLAT = NW;
  localparam int LAT  = DLAT + 3;

  logic en;
  logic [LAT-1:0] v;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid bits march with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[LAT-2:0], in_valid};
      out_valid <= v[LAT-1];
    end
  end

  // Stage 1: products and simple sums.
  logic [3:0] op1;
  logic signed [63:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [DW:0] s_re, s_im;
  logic signed [DW-1:0] br1, bi1;
  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= opcode;
      br1  <= b_re;
      bi1  <= b_im;
      p_rr <= 64'(a_re) * 64'(b_re);
      p_ii <= 64'(a_im) * 64'(b_im);
      p_ir <= 64'(a_im) * 64'(b_re);
      p_ri <= 64'(a_re) * 64'(b_im);
      case (opcode)
        OP_ADD:  begin s_re <= a_re + b_re; s_im <= a_im + b_im; end
        OP_SUB:  begin s_re <= a_re - b_re; s_im <= a_im - b_im; end
        OP_ADDR: begin s_re <= a_re + b_re; s_im <= 33'(a_im); end
        OP_SUBR: begin s_re <= a_re - b_re; s_im <= 33'(a_im); end
        OP_CONJ: begin s_re <= 33'(a_re);   s_im <= -33'(a_im); end
        OP_NEG:  begin s_re <= -33'(a_re);  s_im <= -33'(a_im); end
        OP_DIVR: begin s_re <= 33'(a_re);   s_im <= 33'(a_im); end
        default: begin s_re <= '0;          s_im <= '0; end
      endcase
    end
  end

  // Stage 2: exact sums of products and the divisor.
  logic [3:0] op2;
  logic signed [65:0] x_re, x_im;
  logic [63:0] den2;
  logic signed [DW:0] s2_re, s2_im;
  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      s2_re <= s_re;
      s2_im <= s_im;
      case (op1)
        OP_MUL: begin
          x_re <= 66'(p_rr) - 66'(p_ii);
          x_im <= 66'(p_ir) + 66'(p_ri);
          den2 <= '0;
        end
        OP_DIV: begin
          x_re <= 66'(p_rr) + 66'(p_ii);
          x_im <= 66'(p_ir) - 66'(p_ri);
          // |B|^2 never exceeds 2^63
          den2 <= 64'(br1) * 64'(br1) + 64'(bi1) * 64'(bi1);
        end
        OP_SCALE: begin
          x_re <= 66'(p_rr);
          x_im <= 66'(p_ir);
          den2 <= '0;
        end
        OP_DIVR: begin
          x_re <= 66'(s_re);
          x_im <= 66'(s_im);
          den2 <= br1[DW-1] ? 64'(-65'(br1)) : 64'(br1);
        end
        default: begin
          x_re <= '0;
          x_im <= '0;
          den2 <= '0;
        end
      endcase
    end
  end

  // Stage 3: sign and magnitude, fractional shift, divide-by-zero detect.
  ctl_t c3;
  logic [65:0] m_re, m_im;
  logic [63:0] den3;
  logic signed [DW:0] s3_re, s3_im;
  logic nbr;
  always_ff @(posedge clk) begin
    if (en) begin
      c3.op     <= op2;
      c3.neg_re <= x_re[65];
      c3.neg_im <= x_im[65];
      c3.dz     <= (op2 == OP_DIV || op2 == OP_DIVR) && den2 == '0;
      m_re      <= x_re[65] ? -x_re : x_re;
      m_im      <= x_im[65] ? -x_im : x_im;
      den3      <= den2;
      s3_re     <= s2_re;
      s3_im     <= s2_im;
    end
  end

  // Sign of b_re for real divide travels alongside.
  logic [2:0] bsg;
  always_ff @(posedge clk) begin
    if (en) bsg <= {bsg[1:0], b_re[DW-1]};
  end
  assign nbr = bsg[2];

  // Divider operands; divide-by-zero uses a divisor of one to stay defined.
  logic [NW-1:0] num_re, num_im;
  logic [63:0] dd;
  assign num_re = NW'(m_re[63:0]) << FRAC_BITS;
  assign num_im = NW'(m_im[63:0]) << FRAC_BITS;
  assign dd     = (den3 == '0) ? 64'd1 : den3;

  logic [QW-1:0] q_re, q_im;
  cau_div u_div_re (.clk, .en, .num(num_re), .den(dd), .quo(q_re));
  cau_div u_div_im (.clk, .en, .num(num_im), .den(dd), .quo(q_im));

  // Side data delayed to match the divider.
  typedef struct packed {
    ctl_t c;
    logic nb;
    logic [65:0] mr;
    logic [65:0] mi;
    logic signed [DW:0] sr;
    logic signed [DW:0] si;
  } side_t;
  side_t sd [DLAT+1];
  assign sd[0] = '{c: c3, nb: nbr, mr: m_re, mi: m_im, sr: s3_re, si: s3_im};
  for (genvar k = 0; k < DLAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) sd[k+1] <= sd[k];
    end
  end

  // Saturate a sign-magnitude value.
  function automatic logic [DW:0] sat(input logic neg, input logic [65:0] mag);
    logic [DW:0] r;
    if (!neg) r = (mag > 66'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, mag[31:0]};
    else r = (mag > 66'h8000_0000) ? {1'b1, 32'h8000_0000}
                                   : {1'b0, 32'(-mag[31:0])};
    return r;
  endfunction

  function automatic logic [DW:0] sat_s(input logic signed [DW:0] x);
    return sat(x[DW], x[DW] ? 66'(-x) : 66'(x));
  endfunction

  // Final stage: select, saturate, register the result.
  side_t f;
  logic [DW:0] r_re, r_im;
  logic [65:0] sh_re, sh_im;
  logic nq_re, nq_im;
  logic dzf;
  assign f     = sd[DLAT];
  assign sh_re = f.c.neg_re ? ((f.mr + 66'((1 << FRAC_BITS) - 1)) >> FRAC_BITS)
                            : (f.mr >> FRAC_BITS);
  assign sh_im = f.c.neg_im ? ((f.mi + 66'((1 << FRAC_BITS) - 1)) >> FRAC_BITS)
                            : (f.mi >> FRAC_BITS);
  assign nq_re = (f.c.op == OP_DIVR) ? (f.c.neg_re ^ f.nb) : f.c.neg_re;
  assign nq_im = (f.c.op == OP_DIVR) ? (f.c.neg_im ^ f.nb) : f.c.neg_im;
  assign dzf   = f.c.dz;

  always_comb begin
    r_re = '0;
    r_im = '0;
    case (f.c.op)
      OP_ADD, OP_SUB, OP_ADDR, OP_SUBR, OP_CONJ, OP_NEG: begin
        r_re = sat_s(f.sr);
        r_im = sat_s(f.si);
      end
      OP_MUL, OP_SCALE: begin
        r_re = sat(f.c.neg_re, sh_re);
        r_im = sat(f.c.neg_im, sh_im);
      end
      OP_DIV, OP_DIVR: begin
        if (!dzf) begin
          r_re = sat(nq_re, 66'(q_re));
          r_im = sat(nq_im, 66'(q_im));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re      <= r_re[DW-1:0];
      res_im      <= r_im[DW-1:0];
      overflow    <= r_re[DW] | r_im[DW];
      div_by_zero <= dzf;
    end
  end
endmodule

[test/testbench.sv]
// Self-checking testbench for the complex arithmetic unit: random and directed operations.
module testbench;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 84;
  localparam int N_RANDOM = 1730;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] ar, ai, br, bi;
  } operation_t;

  typedef struct {
    logic [31:0] re, im;
    logic        ovf, dz;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_taken = 1'b0;
  logic [3:0] opcode = '0;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] res_re, res_im;
  logic overflow, div_by_zero;

  operation_t pending_ops[$];
  answer_t    expected_answers[$];
  int         error_count = 0;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 68;
  int         hold_cycles = 0;
  bit         hold_req = 1'b0;
  bit         hold_taken = 1'b0;

  complex_arithmetic_unit dut (.*);

  always #6 clk = ~clk;

  // Saturate a signed value held in 130 bits to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [129:0] v, ref logic ovf);
    if (v > 130'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -130'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Truncating division of (num << FRAC_BITS) by den
  function automatic logic signed [129:0] quot_tz(input logic signed [129:0] num,
                                                  input logic signed [129:0] den);
    logic signed [129:0] n, d, q;
    n = num <<< FRAC_BITS;
    d = den;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic answer_t complex_result(input operation_t t);
    answer_t r;
    logic signed [129:0] ar, ai, br, bi, x, y, den;
    logic ovf;
    ar = $signed(t.ar); ai = $signed(t.ai); br = $signed(t.br); bi = $signed(t.bi);
    ovf = 1'b0;
    r.dz = 1'b0;
    x = 0;
    y = 0;
    case (t.op)
      OP_ADD: begin x = ar + br; y = ai + bi; end
      OP_SUB: begin x = ar - br; y = ai - bi; end
      OP_MUL: begin
        x = (ar * br - ai * bi) >>> FRAC_BITS;
        y = (ai * br + ar * bi) >>> FRAC_BITS;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          x = quot_tz(ar * br + ai * bi, den);
          y = quot_tz(ai * br - ar * bi, den);
        end
      end
      OP_ADDR: begin x = ar + br; y = ai; end
      OP_SUBR: begin x = ar - br; y = ai; end
      OP_SCALE: begin x = (ar * br) >>> FRAC_BITS; y = (ai * br) >>> FRAC_BITS; end
      OP_DIVR: begin
        if (br == 0) r.dz = 1'b1;
        else begin
          x = quot_tz(ar, br);
          y = quot_tz(ai, br);
        end
      end
      OP_CONJ: begin x = ar; y = -ai; end
      OP_NEG: begin x = -ar; y = -ai; end
      default: ;
    endcase
    r.re = clamp32(x, ovf);
    r.im = clamp32(y, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] operand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      5: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom();
    endcase
  endfunction

  function automatic operation_t make_op(input logic [3:0] op, input logic [31:0] ar,
                                         input logic [31:0] ai, input logic [31:0] br,
                                         input logic [31:0] bi);
    operation_t t;
    t.op = op; t.ar = ar; t.ai = ai; t.br = br; t.bi = bi;
    return t;
  endfunction

  // Input transfer seen at the rising edge
  always @(posedge clk) in_taken <= !rst && in_valid && in_ready;

  // Driver: offer the next item at the falling edge, hold it until transfer
  always @(negedge clk) begin
    if (!rst && (in_taken || !in_valid)) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        opcode <= pending_ops[0].op; a_re <= pending_ops[0].ar; a_im <= pending_ops[0].ai;
        b_re <= pending_ops[0].br; b_im <= pending_ops[0].bi;
        expected_answers.push_back(complex_result(pending_ops.pop_front()));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver readiness, with one long hold-off when requested
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req && !hold_taken) begin
        hold_taken  <= 1'b1;
        hold_cycles <= 300;
        out_ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_ready   <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result re=%h im=%h", res_re, res_im);
        error_count++;
      end else begin
        e = expected_answers.pop_front();
        if (res_re !== e.re) begin
          $error("res_re expected %h actual %h", e.re, res_re); error_count++;
        end
        if (res_im !== e.im) begin
          $error("res_im expected %h actual %h", e.im, res_im); error_count++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %b actual %b", e.ovf, overflow); error_count++;
        end
        if (div_by_zero !== e.dz) begin
          $error("div_by_zero expected %b actual %b", e.dz, div_by_zero); error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    logic [3:0] op;
    logic [31:0] br, bi;
    for (int i = 0; i < n; i++) begin
      op = 4'($urandom_range(0, 15));
      if (op > 4'd9 && $urandom_range(0, 3) != 0) op = 4'($urandom_range(0, 9));
      br = operand_value();
      bi = operand_value();
      pending_ops.push_back(make_op(op, operand_value(), operand_value(), br, bi));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: every opcode, extremes, zero divisors, negation of the minimum
    for (int op = 0; op < 16; op++)
      pending_ops.push_back(make_op(4'(op), 32'h0003_8000, 32'hFFFE_4000,
                                    32'h0001_8000, 32'h0002_0000));
    pending_ops.push_back(make_op(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_ops.push_back(make_op(OP_DIVR, 32'h1234_5678, 32'h8000_0000, 0, 32'h0001_0000));
    pending_ops.push_back(make_op(OP_NEG, 32'h8000_0000, 32'h8000_0000, 0, 0));
    pending_ops.push_back(make_op(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 0, 0));
    pending_ops.push_back(make_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF));
    pending_ops.push_back(make_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000));
    pending_ops.push_back(make_op(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0));
    pending_ops.push_back(make_op(OP_DIVR, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1));
    pending_ops.push_back(make_op(OP_SCALE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 0));
    queue_random(N_RANDOM / 3);
    // Sender pauses until everything has come back
    wait_drained();
    send_idle_pct = 68;
    recv_idle_pct = 18;
    queue_random(N_RANDOM / 3);
    wait_drained();
    // No idling, with one long receiver stall while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    queue_random(N_RANDOM / 3);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
